// ----- sv/aapr_pkg.sv -----
// shared types, register codes and widths for the axis-angle point rotation core
// no dependencies; used by every module of the block

package aapr_pkg;

    localparam int COORD_W      = 32;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int COEF_W       = 30;
    localparam int PROD_W       = COORD_W + COEF_W;
    localparam int SUM_W        = 64;
    localparam int COEF_LATENCY = 3;
    localparam int SETTLE_W     = 2;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_COS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_Z = 3'd4;

    localparam logic signed [CFG_W-1:0] ONE_Q14 = 16'sd16384;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } point_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] rotated_x;
        logic signed [COORD_W-1:0] rotated_y;
        logic signed [COORD_W-1:0] rotated_z;
    } point_out_t;

    typedef struct packed {
        logic signed [CFG_W-1:0] cos_of_angle;
        logic signed [CFG_W-1:0] sin_of_angle;
        logic signed [CFG_W-1:0] axis_x;
        logic signed [CFG_W-1:0] axis_y;
        logic signed [CFG_W-1:0] axis_z;
    } cfg_t;

    typedef logic signed [COEF_W-1:0] coef_word_t;

    // rotation matrix in Q.24, indexed [row][column]
    typedef coef_word_t [2:0][2:0] coef_t;

endpackage

// ----- sv/axis_angle_point_rotation_core.sv -----
// Axis-angle point rotation core: rotates one Q16.16 point per beat about a
// configured axis by a configured angle (Rodrigues rotation matrix).
// Input channel in_valid / in_stall / in_data carries point_x, point_y and
// point_z; output channel out_valid / out_stall / out_data carries the
// rotated and saturated rotated_x, rotated_y and rotated_z.
// The configuration port (cfg_valid / cfg_ready, cfg_index, cfg_data) loads
// cos, sin and the axis in Q2.14; indexes past the last register are dropped.
// Write configuration only while no points are in flight.
// An accepted input beat passes through the input register, the multiply stage,
// the row-sum stage and the output register before it shows on out_valid.
// Throughput: one point per cycle while in_stall is low, set by the nine 30x32
// multipliers of the multiply stage running in parallel.
// After reset and after each configuration write, in_stall stays high while
// the coefficient pipeline recomputes the matrix.
// Reset gives the identity rotation and empties the pipeline.
// When the receiver stalls, the result holds and the stages fill behind it;
// in_stall rises once all four stages hold a point.
// Depends on aapr_pkg, aapr_cfg_regs, aapr_coef and aapr_datapath.

module axis_angle_point_rotation_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [aapr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [aapr_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  aapr_pkg::point_in_t              in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output aapr_pkg::point_out_t             out_data
);

    aapr_pkg::cfg_t    cfg;
    aapr_pkg::coef_t   coef;
    logic              busy;

    aapr_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .busy      (busy)
    );

    aapr_coef u_coef
    (
        .clk  (clk),
        .cfg  (cfg),
        .coef (coef)
    );

    aapr_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .hold      (busy),
        .coef      (coef),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

`ifndef SYNTHESIS
    // no point may enter while the matrix is still being recomputed
    a_hold_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> in_stall)
        else $error("point accepted while coefficients settle");

    a_stall_after_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> in_stall)
        else $error("input not held off after a configuration write");

    // with the receiver free, a beat comes out after the pipeline depth
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !out_stall) ##1 !out_stall ##1 !out_stall
        ##1 !out_stall |=> out_valid)
        else $error("result missing after pipeline latency");
`endif

endmodule

// ----- sv/aapr_cfg_regs.sv -----
// configuration registers and the settle counter that holds off points
// while the matrix recomputes; depends on aapr_pkg

module aapr_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [aapr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [aapr_pkg::CFG_W-1:0]       cfg_data,
    output aapr_pkg::cfg_t                   cfg,
    output logic                             busy
);

    aapr_pkg::cfg_t                  cfg_reg;
    aapr_pkg::cfg_t                  cfg_next;
    logic [aapr_pkg::SETTLE_W-1:0]   settle_reg;
    logic [aapr_pkg::SETTLE_W-1:0]   settle_next;
    logic                            wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (cfg_index)
                aapr_pkg::CFG_COS:    cfg_next.cos_of_angle = cfg_data;
                aapr_pkg::CFG_SIN:    cfg_next.sin_of_angle = cfg_data;
                aapr_pkg::CFG_AXIS_X: cfg_next.axis_x       = cfg_data;
                aapr_pkg::CFG_AXIS_Y: cfg_next.axis_y       = cfg_data;
                aapr_pkg::CFG_AXIS_Z: cfg_next.axis_z       = cfg_data;
                default:              cfg_next              = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        settle_next = settle_reg;
        if (wr)
        begin
            settle_next = aapr_pkg::SETTLE_W'(aapr_pkg::COEF_LATENCY);
        end
        else if (settle_reg != '0)
        begin
            settle_next = settle_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cos_of_angle <= aapr_pkg::ONE_Q14;
            cfg_reg.sin_of_angle <= '0;
            cfg_reg.axis_x       <= '0;
            cfg_reg.axis_y       <= '0;
            cfg_reg.axis_z       <= aapr_pkg::ONE_Q14;
            // coefficient registers carry no reset, so wait for them to fill
            settle_reg           <= aapr_pkg::SETTLE_W'(aapr_pkg::COEF_LATENCY);
        end
        else
        begin
            cfg_reg    <= cfg_next;
            settle_reg <= settle_next;
        end
    end

    assign cfg  = cfg_reg;
    assign busy = (settle_reg != '0);

endmodule

// ----- sv/aapr_coef.sv -----
// three-stage pipeline forming the nine rotation coefficients from the
// configuration registers, rounded to Q.24; depends on aapr_pkg

module aapr_coef
(
    input  logic              clk,
    input  aapr_pkg::cfg_t    cfg,
    output aapr_pkg::coef_t   coef
);

    localparam int SQ_W   = 32;
    localparam int OMC_W  = 17;
    localparam int DIAG_W = 48;
    localparam int OFF_W  = 49;
    localparam int ACC_W  = 50;
    localparam int Q_SH   = 18;

    localparam logic signed [SQ_W-1:0]  ONE_Q28     = 32'sd268435456;
    localparam logic signed [ACC_W-1:0] COEF_ROUND  = 50'sd131072;
    localparam logic signed [OMC_W-1:0] ONE_Q14_EXT = 17'sd16384;

    // stage 1: pairwise products of the registers
    logic signed [aapr_pkg::CFG_W-1:0] c1_c_reg;
    logic signed [OMC_W-1:0]           c1_omc_reg;
    logic signed [SQ_W-1:0]            c1_sq_reg [3];
    logic signed [SQ_W-1:0]            c1_cross_reg [3];
    logic signed [SQ_W-1:0]            c1_su_reg [3];

    // stage 2: products with cos and with one minus cos
    logic signed [SQ_W-1:0]            c2_sq_reg [3];
    logic signed [DIAG_W-1:0]          c2_diag_reg [3];
    logic signed [OFF_W-1:0]           c2_off_reg [3];
    logic signed [SQ_W-1:0]            c2_su_reg [3];

    // stage 3: sums and rounding
    aapr_pkg::coef_t                   coef_reg;
    aapr_pkg::coef_t                   coef_next;

    logic signed [aapr_pkg::CFG_W-1:0] u [3];
    logic signed [SQ_W-1:0]            diag_base [3];
    logic signed [ACC_W-1:0]           acc [3][3];

    function automatic aapr_pkg::coef_word_t round_coef(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = (v + COEF_ROUND) >>> Q_SH;
        return t[aapr_pkg::COEF_W-1:0];
    endfunction

    assign u[0] = cfg.axis_x;
    assign u[1] = cfg.axis_y;
    assign u[2] = cfg.axis_z;

    always_ff @(posedge clk)
    begin
        c1_c_reg        <= cfg.cos_of_angle;
        c1_omc_reg      <= $signed({ONE_Q14_EXT[OMC_W-1], ONE_Q14_EXT[OMC_W-2:0]})
                           - $signed({cfg.cos_of_angle[aapr_pkg::CFG_W-1], cfg.cos_of_angle});
        for (int i = 0; i < 3; i++)
        begin
            c1_sq_reg[i] <= u[i] * u[i];
            c1_su_reg[i] <= u[i] * cfg.sin_of_angle;
        end
        c1_cross_reg[0] <= u[0] * u[1];
        c1_cross_reg[1] <= u[0] * u[2];
        c1_cross_reg[2] <= u[1] * u[2];
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diag_base[i] = ONE_Q28 - c1_sq_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            c2_sq_reg[i]   <= c1_sq_reg[i];
            c2_diag_reg[i] <= diag_base[i] * c1_c_reg;
            c2_off_reg[i]  <= c1_cross_reg[i] * c1_omc_reg;
            c2_su_reg[i]   <= c1_su_reg[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc[i][i] = (ACC_W'(c2_sq_reg[i]) <<< 14) + ACC_W'(c2_diag_reg[i]);
        end
        // off-diagonal terms: cross term times (1 - c), plus or minus sin times axis
        acc[0][1] = ACC_W'(c2_off_reg[0]) - (ACC_W'(c2_su_reg[2]) <<< 14);
        acc[1][0] = ACC_W'(c2_off_reg[0]) + (ACC_W'(c2_su_reg[2]) <<< 14);
        acc[0][2] = ACC_W'(c2_off_reg[1]) + (ACC_W'(c2_su_reg[1]) <<< 14);
        acc[2][0] = ACC_W'(c2_off_reg[1]) - (ACC_W'(c2_su_reg[1]) <<< 14);
        acc[1][2] = ACC_W'(c2_off_reg[2]) - (ACC_W'(c2_su_reg[0]) <<< 14);
        acc[2][1] = ACC_W'(c2_off_reg[2]) + (ACC_W'(c2_su_reg[0]) <<< 14);
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                coef_next[i][j] = round_coef(acc[i][j]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        coef_reg <= coef_next;
    end

    assign coef = coef_reg;

endmodule

// ----- sv/aapr_datapath.sv -----
// four-stage point pipeline: input register, nine multiplies, row sums with rounding,
// shift with saturation into the output register; depends on aapr_pkg

module aapr_datapath
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   hold,
    input  aapr_pkg::coef_t        coef,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  aapr_pkg::point_in_t    in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output aapr_pkg::point_out_t   out_data
);

    localparam int SH_W = aapr_pkg::SUM_W - 24;

    localparam logic signed [aapr_pkg::SUM_W-1:0] OUT_ROUND = 64'sd8388608;
    localparam logic signed [SH_W-1:0] SAT_MAX = 40'sd2147483647;
    localparam logic signed [SH_W-1:0] SAT_MIN = -40'sd2147483648;

    logic                                  v0_reg;
    logic                                  v1_reg;
    logic                                  v2_reg;
    logic                                  v3_reg;
    aapr_pkg::point_in_t                   p0_reg;
    logic signed [aapr_pkg::PROD_W-1:0]    prod_reg [3][3];
    logic signed [aapr_pkg::SUM_W-1:0]     sum_reg [3];
    aapr_pkg::point_out_t                  out_reg;

    logic                                  rdy0;
    logic                                  rdy1;
    logic                                  rdy2;
    logic                                  rdy3;
    logic signed [aapr_pkg::COORD_W-1:0]   pt [3];
    logic signed [aapr_pkg::SUM_W-1:0]     sum_next [3];
    logic signed [SH_W-1:0]                sh [3];
    logic signed [aapr_pkg::COORD_W-1:0]   sat [3];

    // a stage moves on when it is empty or the one after it moves
    assign rdy3     = !v3_reg || !out_stall;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign rdy0     = !v0_reg || rdy1;
    assign in_stall = !rdy0 || hold;

    assign pt[0] = p0_reg.point_x;
    assign pt[1] = p0_reg.point_y;
    assign pt[2] = p0_reg.point_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum_next[i] = aapr_pkg::SUM_W'(prod_reg[i][0]) + aapr_pkg::SUM_W'(prod_reg[i][1])
                        + aapr_pkg::SUM_W'(prod_reg[i][2]) + OUT_ROUND;
            sh[i]       = sum_reg[i][aapr_pkg::SUM_W-1:24];
            if (sh[i] > SAT_MAX)
            begin
                sat[i] = SAT_MAX[aapr_pkg::COORD_W-1:0];
            end
            else if (sh[i] < SAT_MIN)
            begin
                sat[i] = SAT_MIN[aapr_pkg::COORD_W-1:0];
            end
            else
            begin
                sat[i] = sh[i][aapr_pkg::COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy0)
            begin
                v0_reg <= in_valid && !hold;
            end
            if (rdy1)
            begin
                v1_reg <= v0_reg;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy0)
        begin
            p0_reg <= in_data;
        end
        if (rdy1)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    prod_reg[i][j] <= $signed(coef[i][j]) * pt[j];
                end
            end
        end
        if (rdy2)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i] <= sum_next[i];
            end
        end
        if (rdy3)
        begin
            out_reg.rotated_x <= sat[0];
            out_reg.rotated_y <= sat[1];
            out_reg.rotated_z <= sat[2];
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = out_reg;

endmodule

// ----- dv/tb_axis_angle_point_rotation_core.sv -----
// testbench for axis_angle_point_rotation_core: streams points through the core under
// several rotation settings and checks each rotated point against a fixed-point predictor
// depends on aapr_pkg and the core rtl
`timescale 1ns / 1ps

module tb_axis_angle_point_rotation_core;

    localparam longint UNIT_Q14 = 64'sd16384;
    localparam longint UNIT_Q28 = 64'sd268435456;
    localparam longint Q16_MAX  = 64'sd2147483647;
    localparam longint Q16_MIN  = -64'sd2147483648;

    localparam logic signed [aapr_pkg::COORD_W-1:0] COORD_MAX = 32'sh7fffffff;
    localparam logic signed [aapr_pkg::COORD_W-1:0] COORD_MIN = 32'sh80000000;
    localparam logic [aapr_pkg::CFG_W-1:0] REG_MAX  = 16'h7fff;
    localparam logic [aapr_pkg::CFG_W-1:0] REG_MIN  = 16'h8000;
    localparam logic [aapr_pkg::CFG_W-1:0] REG_ZERO = 16'h0000;
    localparam logic [aapr_pkg::CFG_W-1:0] REG_ONE  = 16'h4000;

    localparam int LATENCY_SLACK = 8;
    localparam int QUIET_LIMIT   = 5000;
    localparam int LONG_HOLD     = 400;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_POINTS  = 108;

    localparam aapr_pkg::cfg_t RESET_REGS = '{
        cos_of_angle: aapr_pkg::ONE_Q14,
        sin_of_angle: '0,
        axis_x:       '0,
        axis_y:       '0,
        axis_z:       aapr_pkg::ONE_Q14
    };

    typedef enum logic [1:0] {STALL_OFF, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [aapr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [aapr_pkg::CFG_W-1:0]     cfg_data  = '0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    aapr_pkg::point_in_t            in_data   = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    aapr_pkg::point_out_t           out_data;

    aapr_pkg::point_in_t  points_to_send [$];
    aapr_pkg::point_out_t rotated_expected [$];
    aapr_pkg::cfg_t       rotation_regs = RESET_REGS;
    int                   error_count = 0;

    int          burst_left = 0;
    int          gap_left   = 0;
    stall_mode_t stall_mode = STALL_OFF;
    int          mode_left  = 0;
    int          hold_left  = 0;
    logic        hold_req   = 1'b0;
    logic        hold_done  = 1'b0;
    int          quiet_cycles = 0;

    axis_angle_point_rotation_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // floor((v + half) / 2^sh), i.e. round half up
    function automatic longint round_shift(input longint v, input int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic logic signed [aapr_pkg::COORD_W-1:0] clamp_q16(input longint v);
        if (v > Q16_MAX)
            return COORD_MAX;
        if (v < Q16_MIN)
            return COORD_MIN;
        return v[aapr_pkg::COORD_W-1:0];
    endfunction

    function automatic aapr_pkg::point_out_t rotate_point(input aapr_pkg::cfg_t r,
                                                          input aapr_pkg::point_in_t pt);
        longint               c, s, ux, uy, uz, omc, uxx, uyy, uzz, acc;
        longint               m [0:2][0:2];
        longint               p [0:2];
        longint               row [0:2];
        int                   i, j;
        aapr_pkg::point_out_t q;
        c   = longint'(r.cos_of_angle);
        s   = longint'(r.sin_of_angle);
        ux  = longint'(r.axis_x);
        uy  = longint'(r.axis_y);
        uz  = longint'(r.axis_z);
        omc = UNIT_Q14 - c;
        uxx = ux * ux;
        uyy = uy * uy;
        uzz = uz * uz;
        // rotation matrix in Q.42: c*I + s*[u]x + (1-c)*u*u^T, axis taken as loaded
        m[0][0] = uxx * UNIT_Q14 + (UNIT_Q28 - uxx) * c;
        m[0][1] = ux * uy * omc - uz * s * UNIT_Q14;
        m[0][2] = ux * uz * omc + uy * s * UNIT_Q14;
        m[1][0] = ux * uy * omc + uz * s * UNIT_Q14;
        m[1][1] = uyy * UNIT_Q14 + (UNIT_Q28 - uyy) * c;
        m[1][2] = uy * uz * omc - ux * s * UNIT_Q14;
        m[2][0] = ux * uz * omc - uy * s * UNIT_Q14;
        m[2][1] = uy * uz * omc + ux * s * UNIT_Q14;
        m[2][2] = uzz * UNIT_Q14 + (UNIT_Q28 - uzz) * c;
        p[0] = longint'(pt.point_x);
        p[1] = longint'(pt.point_y);
        p[2] = longint'(pt.point_z);
        for (i = 0; i < 3; i++)
        begin
            acc = 0;
            for (j = 0; j < 3; j++)
                acc += round_shift(m[i][j], 18) * p[j];
            row[i] = round_shift(acc, 24);
        end
        q.rotated_x = clamp_q16(row[0]);
        q.rotated_y = clamp_q16(row[1]);
        q.rotated_z = clamp_q16(row[2]);
        return q;
    endfunction

    task automatic check_field(input string name,
                               input logic signed [aapr_pkg::COORD_W-1:0] want,
                               input logic signed [aapr_pkg::COORD_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    function automatic logic [aapr_pkg::COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0, 1, 2: return $urandom;
            3, 4:    return $urandom_range(0, 32'h001fffff) - 32'h00100000;
            5:       return $urandom_range(0, 32'h01ffffff) - 32'h01000000;
            6:       return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
            default: return $urandom_range(0, 4) - 2;
        endcase
    endfunction

    function automatic aapr_pkg::point_in_t rand_point();
        aapr_pkg::point_in_t pt;
        pt.point_x = rand_coord();
        pt.point_y = rand_coord();
        pt.point_z = rand_coord();
        return pt;
    endfunction

    function automatic logic [aapr_pkg::CFG_W-1:0] rand_reg_value();
        case ($urandom_range(0, 5))
            0:       return REG_MIN;
            1:       return REG_MAX;
            2:       return REG_ZERO;
            3:       return REG_ONE;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [aapr_pkg::CFG_W-1:0] to_q14(input real x);
        int v;
        v = $rtoi(x * 16384.0 + ((x < 0.0) ? -0.5 : 0.5));
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[aapr_pkg::CFG_W-1:0];
    endfunction

    task automatic queue_point(input logic [aapr_pkg::COORD_W-1:0] x,
                               input logic [aapr_pkg::COORD_W-1:0] y,
                               input logic [aapr_pkg::COORD_W-1:0] z);
        aapr_pkg::point_in_t pt;
        pt.point_x = x;
        pt.point_y = y;
        pt.point_z = z;
        points_to_send.insert(points_to_send.size(), pt);
    endtask

    task automatic write_reg(input logic [aapr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [aapr_pkg::CFG_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_config(input logic [aapr_pkg::CFG_W-1:0] c,
                               input logic [aapr_pkg::CFG_W-1:0] s,
                               input logic [aapr_pkg::CFG_W-1:0] x,
                               input logic [aapr_pkg::CFG_W-1:0] y,
                               input logic [aapr_pkg::CFG_W-1:0] z);
        write_reg(aapr_pkg::CFG_COS, c);
        write_reg(aapr_pkg::CFG_SIN, s);
        write_reg(aapr_pkg::CFG_AXIS_X, x);
        write_reg(aapr_pkg::CFG_AXIS_Y, y);
        write_reg(aapr_pkg::CFG_AXIS_Z, z);
    endtask

    // a proper rotation; a scale other than one gives a non-unit axis
    task automatic load_random_rotation(input real axis_scale);
        real angle, ax, ay, az, len;
        angle = real'($urandom_range(0, 62831)) / 10000.0;
        ax = real'($urandom_range(0, 2000)) - 1000.0;
        ay = real'($urandom_range(0, 2000)) - 1000.0;
        az = real'($urandom_range(0, 2000)) - 1000.0;
        len = $sqrt(ax * ax + ay * ay + az * az);
        if (len < 1.0)
        begin
            ax = 0.0;
            ay = 0.0;
            az = 1.0;
            len = 1.0;
        end
        load_config(to_q14($cos(angle)), to_q14($sin(angle)), to_q14(axis_scale * ax / len),
                    to_q14(axis_scale * ay / len), to_q14(axis_scale * az / len));
    endtask

    // wait until every queued point has come back, then let the pipeline go quiet
    task automatic settle();
        while (points_to_send.size() != 0 || in_valid || rotated_expected.size() != 0)
            @(negedge clk);
        repeat (LATENCY_SLACK) @(negedge clk);
    endtask

    // point driver: bursts of beats with random gaps between them
    always @(posedge clk)
    begin
        if (rst_n && (!in_valid || !in_stall))
        begin
            if (gap_left != 0 || points_to_send.size() == 0)
            begin
                in_valid <= 1'b0;
                if (gap_left != 0)
                    gap_left--;
            end
            else
            begin
                in_valid <= 1'b1;
                in_data  <= points_to_send.pop_front();
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                    burst_left--;
            end
        end
    end

    // receiver stall pattern, with one long hold-off to fill the core
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (hold_req && !hold_done)
        begin
            out_stall <= 1'b1;
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                mode_left  = $urandom_range(16, 200);
            end
            else
                mode_left--;
            case (stall_mode)
                STALL_OFF:   out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                default:     out_stall <= ((mode_left % 5) < 2);
            endcase
        end
    end

    // register shadow, prediction on each input beat and checking on each output beat
    always @(posedge clk)
    begin
        aapr_pkg::point_out_t want;
        if (!rst_n)
            rotation_regs = RESET_REGS;
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    aapr_pkg::CFG_COS:    rotation_regs.cos_of_angle = cfg_data;
                    aapr_pkg::CFG_SIN:    rotation_regs.sin_of_angle = cfg_data;
                    aapr_pkg::CFG_AXIS_X: rotation_regs.axis_x = cfg_data;
                    aapr_pkg::CFG_AXIS_Y: rotation_regs.axis_y = cfg_data;
                    aapr_pkg::CFG_AXIS_Z: rotation_regs.axis_z = cfg_data;
                    default:              ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (rotated_expected.size() == 0)
                begin
                    $error("rotated point with no input beat waiting: %h", out_data);
                    error_count++;
                end
                else
                begin
                    want = rotated_expected.pop_front();
                    check_field("rotated_x", want.rotated_x, out_data.rotated_x);
                    check_field("rotated_y", want.rotated_y, out_data.rotated_y);
                    check_field("rotated_z", want.rotated_z, out_data.rotated_z);
                end
            end
            if (in_valid && !in_stall)
                rotated_expected.insert(rotated_expected.size(),
                                        rotate_point(rotation_regs, in_data));
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int phase;
        int n;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // identity rotation out of reset
        queue_point(32'sd0, 32'sd0, 32'sd0);
        queue_point(COORD_MAX, COORD_MIN, 32'sd1);
        queue_point(COORD_MIN, COORD_MAX, -32'sd1);
        queue_point(32'sd65536, -32'sd65536, 32'sd32768);
        queue_point(COORD_MAX, COORD_MAX, COORD_MAX);
        queue_point(COORD_MIN, COORD_MIN, COORD_MIN);
        settle();

        // most negative registers: largest coefficients, outputs saturate
        load_config(REG_MIN, REG_MIN, REG_MIN, REG_MIN, REG_MIN);
        queue_point(COORD_MAX, COORD_MAX, COORD_MAX);
        queue_point(COORD_MIN, COORD_MIN, COORD_MIN);
        queue_point(32'sd1, -32'sd1, 32'sd1);
        queue_point(32'sd65536, 32'sd0, 32'sd0);
        settle();

        load_config(REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX);
        queue_point(COORD_MAX, COORD_MAX, COORD_MAX);
        queue_point(COORD_MIN, COORD_MIN, COORD_MIN);
        queue_point(32'sd1, -32'sd1, 32'sd1);
        queue_point(32'sd65536, 32'sd0, 32'sd0);
        settle();

        // quarter turn about z, then writes past the last register that must be dropped
        load_config(REG_ZERO, REG_ONE, REG_ZERO, REG_ZERO, REG_ONE);
        write_reg(aapr_pkg::CFG_AXIS_Z + 3'd1, 16'h5a5a);
        write_reg(aapr_pkg::CFG_AXIS_Z + 3'd2, 16'ha5a5);
        write_reg(aapr_pkg::CFG_AXIS_Z + 3'd3, 16'hffff);
        queue_point(32'sd65536, 32'sd0, 32'sd0);
        queue_point(32'sd0, 32'sd65536, 32'sd0);
        queue_point(32'sd1, 32'sd1, 32'sd1);
        settle();

        load_config(REG_MIN, REG_MAX, REG_MAX, REG_MIN, REG_ZERO);
        queue_point(COORD_MAX, COORD_MIN, COORD_MAX);
        queue_point(-32'sd2, 32'sd3, -32'sd32768);
        queue_point(32'sd123456789, -32'sd987654, 32'sd65535);
        settle();

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase % 3)
                0:       load_random_rotation(1.0);
                1:       load_config(rand_reg_value(), rand_reg_value(), rand_reg_value(),
                                     rand_reg_value(), rand_reg_value());
                default: load_random_rotation(real'($urandom_range(50, 199)) / 100.0);
            endcase
            if ($urandom_range(0, 1) == 1)
                write_reg(aapr_pkg::CFG_AXIS_Z + 3'($urandom_range(1, 3)), 16'($urandom));
            for (n = 0; n < PHASE_POINTS; n++)
                points_to_send.insert(points_to_send.size(), rand_point());
            if (phase == 4)
                hold_req = 1'b1;
            settle();
        end

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
